// File: rtl/core/sfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Types, codes and tile shape tables shared by the sprite frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int TILE_WIDTH     = 32;
	localparam int MAX_RUNS       = 3;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam logic [7:0] FILL_BIAS = 8'd65;
	localparam logic [7:0] ZERO_LEN  = 8'd2;

	typedef enum logic [2:0] {
		FMT_PLAIN  = 3'd0,
		FMT_RLE    = 3'd1,
		FMT_TRI_L  = 3'd2,
		FMT_TRI_R  = 3'd3,
		FMT_TRAP_L = 3'd4,
		FMT_TRAP_R = 3'd5,
		FMT_FILL   = 3'd6
	} fmt_t;

	typedef enum logic [2:0] {
		RUN_REGULAR  = 3'd0,
		RUN_SKIP     = 3'd1,
		RUN_ZERO     = 3'd2,
		RUN_IMPLICIT = 3'd3,
		RUN_END      = 3'd4
	} run_kind_t;

	typedef struct packed {
		run_kind_t  kind;
		logic [7:0] color;
		logic [7:0] len;
		logic       bad;
		logic       done;
	} run_t;

	typedef struct packed {
		logic [1:0]              cnt;
		run_t [MAX_RUNS-1:0]     res;
	} entry_t;

	localparam logic [5:0] TRI_COUNTS [TILE_WIDTH] = '{
		6'd0, 6'd4, 6'd4, 6'd8, 6'd8, 6'd12, 6'd12, 6'd16, 6'd16, 6'd20, 6'd20,
		6'd24, 6'd24, 6'd28, 6'd28, 6'd32, 6'd32, 6'd32, 6'd28, 6'd28, 6'd24,
		6'd24, 6'd20, 6'd20, 6'd16, 6'd16, 6'd12, 6'd12, 6'd8, 6'd8, 6'd4, 6'd4
	};

	localparam logic [5:0] TRAP_COUNTS [TILE_WIDTH] = '{
		6'd4, 6'd4, 6'd8, 6'd8, 6'd12, 6'd12, 6'd16, 6'd16, 6'd20, 6'd20, 6'd24,
		6'd24, 6'd28, 6'd28, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32,
		6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32
	};

	localparam logic [5:0] TRAP_ZERO_LINES [8] = '{
		6'd0, 6'd2, 6'd4, 6'd6, 6'd8, 6'd10, 6'd12, 6'd14
	};

	function automatic logic [5:0] tile_count(input logic trap, input logic [4:0] line);
		return trap ? TRAP_COUNTS[line] : TRI_COUNTS[line];
	endfunction

	function automatic logic tile_has_zeros(input logic trap, input logic [5:0] line);
		logic hit;
		hit = 1'b0;
		if (!trap) begin
			hit = line[0];
		end else begin
			for (int i = 0; i < 8; i++) begin
				if (TRAP_ZERO_LINES[i] == line) begin
					hit = 1'b1;
				end
			end
		end
		return hit;
	endfunction

	function automatic run_t mk_run(input run_kind_t kind, input logic [7:0] color,
		input logic [7:0] len, input logic bad);
		run_t r;
		r.kind  = kind;
		r.color = color;
		r.len   = len;
		r.bad   = bad;
		r.done  = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/sfd_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_ifs
// Valid/ready channels of the decoder: frame bytes in, pixel runs out.
// ----------------------------------------------------------------------------
interface sfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sfd_run_if;
	logic       valid;
	logic       ready;
	logic [2:0] run_kind;
	logic [7:0] color_index;
	logic [7:0] run_length;
	logic       last_result;
	logic       frame_done;
	logic       malformed;

	modport source (output valid, output run_kind, output color_index, output run_length,
		output last_result, output frame_done, output malformed, input ready);
	modport sink   (input valid, input run_kind, input color_index, input run_length,
		input last_result, input frame_done, input malformed, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sfd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_front
// Accepts frame bytes, tracks decode state and turns each byte into a
// queue entry of up to three finished runs.
// ----------------------------------------------------------------------------
module sfd_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire  [2:0]          cfg_wdata,
	input  wire                 in_valid,
	input  wire  [7:0]          in_byte,
	input  wire                 in_last,
	input  wire                 space,
	output logic                in_ready,
	output logic                push,
	output sfd_pkg::entry_t     push_entry
);
	import sfd_pkg::*;

	fmt_t       fmt_q;
	logic [7:0] lit_q, lit_d;
	logic [5:0] fill_q, fill_d;
	logic [5:0] line_q, line_d;
	logic [5:0] pos_q, pos_d;

	entry_t     ent;
	logic [1:0] n;
	logic       early;
	logic       trap, left, has_z;
	logic [5:0] ln, cnt, pos;
	logic [7:0] mag, b;
	logic       take;

	assign in_ready = space;
	assign take     = in_valid && space;
	assign b        = in_byte;

	always_comb begin
		ent    = '0;
		n      = 2'd0;
		early  = 1'b0;
		lit_d  = lit_q;
		fill_d = fill_q;
		line_d = line_q;
		pos_d  = pos_q;
		trap   = (fmt_q == FMT_TRAP_L) || (fmt_q == FMT_TRAP_R);
		left   = (fmt_q == FMT_TRI_L) || (fmt_q == FMT_TRAP_L);
		ln     = line_q;
		pos    = pos_q;
		cnt    = tile_count(trap, ln[4:0]);
		has_z  = 1'b0;
		mag    = 8'd0 - b;
		case (fmt_q)
			FMT_RLE: begin
				if (lit_q != 8'd0) begin
					lit_d = lit_q - 8'd1;
					ent.res[n] = mk_run(RUN_REGULAR, b, 8'd1, 1'b0);
					n = n + 2'd1;
				end else if (b[7]) begin
					ent.res[n] = mk_run(RUN_SKIP, 8'd0, mag, 1'b0);
					n = n + 2'd1;
				end else begin
					lit_d = b;
				end
			end
			FMT_FILL: begin
				if (fill_q != 6'd0) begin
					ent.res[n] = mk_run(RUN_REGULAR, b, {2'b00, fill_q}, 1'b0);
					n = n + 2'd1;
					fill_d = 6'd0;
				end else if (lit_q != 8'd0) begin
					lit_d = lit_q - 8'd1;
					ent.res[n] = mk_run(RUN_REGULAR, b, 8'd1, 1'b0);
					n = n + 2'd1;
				end else if (!b[7]) begin
					if (b != 8'd0) begin
						ent.res[n] = mk_run(RUN_SKIP, 8'd0, b, 1'b0);
						n = n + 2'd1;
					end
				end else if (mag <= FILL_BIAS) begin
					lit_d = mag;
				end else begin
					fill_d = 6'(mag - FILL_BIAS);
				end
			end
			FMT_TRI_L, FMT_TRI_R, FMT_TRAP_L, FMT_TRAP_R: begin
				if (line_q >= 6'(TILE_WIDTH)) begin
					ent.res[n] = mk_run(RUN_END, 8'd0, 8'd0, 1'b1);
					n = n + 2'd1;
				end else begin
					if (cnt == 6'd0) begin
						ent.res[n] = mk_run(RUN_IMPLICIT, 8'd0, 8'(TILE_WIDTH), 1'b0);
						n = n + 2'd1;
						ln  = line_q + 6'd1;
						pos = 6'd0;
						cnt = tile_count(trap, ln[4:0]);
					end
					has_z = tile_has_zeros(trap, ln);
					if (left) begin
						if (pos == 6'd0 && cnt < 6'(TILE_WIDTH)) begin
							ent.res[n] = mk_run(RUN_IMPLICIT, 8'd0,
								8'(TILE_WIDTH) - {2'b00, cnt}, 1'b0);
							n = n + 2'd1;
						end
						if (has_z && pos < 6'd2) begin
							if (pos == 6'd0) begin
								ent.res[n] = mk_run(RUN_ZERO, 8'd0, ZERO_LEN, 1'b0);
								n = n + 2'd1;
							end
						end else begin
							ent.res[n] = mk_run(RUN_REGULAR, b, 8'd1, 1'b0);
							n = n + 2'd1;
						end
					end else begin
						if (!(has_z && pos < 6'd2)) begin
							ent.res[n] = mk_run(RUN_REGULAR, b, 8'd1, 1'b0);
							n = n + 2'd1;
						end
						if (pos + 6'd1 == cnt) begin
							if (has_z) begin
								ent.res[n] = mk_run(RUN_ZERO, 8'd0, ZERO_LEN, 1'b0);
								n = n + 2'd1;
							end
							if (cnt < 6'(TILE_WIDTH)) begin
								ent.res[n] = mk_run(RUN_IMPLICIT, 8'd0,
									8'(TILE_WIDTH) - {2'b00, cnt}, 1'b0);
								n = n + 2'd1;
							end
						end
					end
					if (pos + 6'd1 >= cnt) begin
						pos_d  = 6'd0;
						line_d = ln + 6'd1;
					end else begin
						pos_d  = pos + 6'd1;
						line_d = ln;
					end
				end
			end
			default: begin
				ent.res[n] = mk_run(RUN_REGULAR, b, 8'd1, 1'b0);
				n = n + 2'd1;
			end
		endcase

		if (in_last) begin
			case (fmt_q)
				FMT_RLE:  early = lit_d != 8'd0;
				FMT_FILL: early = (lit_d != 8'd0) || (fill_d != 6'd0);
				FMT_TRI_L, FMT_TRI_R, FMT_TRAP_L, FMT_TRAP_R:
					early = line_d < 6'(TILE_WIDTH);
				default:  early = 1'b0;
			endcase
			if (n == 2'd0) begin
				ent.res[n] = mk_run(RUN_END, 8'd0, 8'd0, 1'b0);
				n = n + 2'd1;
			end
			ent.res[n - 2'd1].done = 1'b1;
			ent.res[n - 2'd1].bad  = ent.res[n - 2'd1].bad | early;
			lit_d  = 8'd0;
			fill_d = 6'd0;
			line_d = 6'd0;
			pos_d  = 6'd0;
		end
		ent.cnt = n;
	end

	assign push       = take && (n != 2'd0);
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= FMT_RLE;
			lit_q  <= 8'd0;
			fill_q <= 6'd0;
			line_q <= 6'd0;
			pos_q  <= 6'd0;
		end else if (cfg_we) begin
			fmt_q  <= fmt_t'(cfg_wdata);
			lit_q  <= 8'd0;
			fill_q <= 6'd0;
			line_q <= 6'd0;
			pos_q  <= 6'd0;
		end else if (take) begin
			lit_q  <= lit_d;
			fill_q <= fill_d;
			line_q <= line_d;
			pos_q  <= pos_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/sfd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_queue
// Short FIFO of decoded entries between the byte side and the run side.
// ----------------------------------------------------------------------------
module sfd_queue #(
	parameter int DEPTH = sfd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  sfd_pkg::entry_t     push_entry,
	input  wire                 pop,
	output logic                space,
	output logic                head_valid,
	output sfd_pkg::entry_t     head
);
	import sfd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign space      = count_q != CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/sfd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_back
// Unpacks queue entries into single run beats through an output register.
// ----------------------------------------------------------------------------
module sfd_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 head_valid,
	input  sfd_pkg::entry_t     head,
	output logic                pop,
	sfd_run_if.source           run_chan
);
	import sfd_pkg::*;

	logic       valid_q;
	logic [1:0] idx_q;
	run_t       cur;
	logic       load, tail;
	run_kind_t  kind_q;
	logic [7:0] color_q, len_q;
	logic       last_q, done_q, bad_q;

	assign cur  = head.res[idx_q];
	assign load = head_valid && (!valid_q || run_chan.ready);
	assign tail = idx_q == head.cnt - 2'd1;
	assign pop  = load && tail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= tail ? 2'd0 : idx_q + 2'd1;
			end else if (run_chan.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= cur.kind;
			color_q <= cur.color;
			len_q   <= cur.len;
			last_q  <= tail;
			done_q  <= cur.done;
			bad_q   <= cur.bad;
		end
	end

	assign run_chan.valid       = valid_q;
	assign run_chan.run_kind    = kind_q;
	assign run_chan.color_index = color_q;
	assign run_chan.run_length  = len_q;
	assign run_chan.last_result = last_q;
	assign run_chan.frame_done  = done_q;
	assign run_chan.malformed   = bad_q;

endmodule
`default_nettype wire

// File: rtl/core/sprite_frame_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_frame_decoder
// Decodes sprite frame bytes (plain, RLE, fill-RLE, tile shapes) into runs.
// ----------------------------------------------------------------------------
// The byte channel takes one beat per cycle while the queue has room; a byte
// is classified in its accept cycle and yields up to three runs. The run
// channel delivers one run beat per cycle from its output register while the
// sink is ready, and a queue of QUEUE_DEPTH entries lets the two sides stall
// independently. Bytes that give no run are not queued. A write on cfg_we
// sets the frame format and restarts the frame; the format has no read-back
// path.
// ----------------------------------------------------------------------------
module sprite_frame_decoder #(
	parameter int QUEUE_DEPTH = sfd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_wdata,
	sfd_byte_if.sink    byte_chan,
	sfd_run_if.source   run_chan
);
	import sfd_pkg::*;

	logic   space, push, pop, head_valid, in_ready;
	entry_t push_entry, head;

	assign byte_chan.ready = in_ready;

	sfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (byte_chan.valid),
		.in_byte    (byte_chan.data_byte),
		.in_last    (byte_chan.last_byte),
		.space      (space),
		.in_ready   (in_ready),
		.push       (push),
		.push_entry (push_entry)
	);

	sfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.space      (space),
		.head_valid (head_valid),
		.head       (head)
	);

	sfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.run_chan   (run_chan)
	);

endmodule
`default_nettype wire
